### sv/scmppt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scmppt_pkg: shared types and constants of the solar charge controller
// Mode encoding, register indexes and reset values, and the control and
// payload structs passed between the controller modules.
// ----------------------------------------------------------------------------
package scmppt_pkg;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 24;
   localparam int unsigned DUTY_W      = 10;
   localparam int unsigned STEP_W      = 7;
   localparam int unsigned SOC_W       = 10;
   localparam int unsigned POWER_W     = 24;
   localparam int unsigned NPOWER_W    = 25;
   localparam int unsigned VOLT_W      = 16;

   localparam logic [DUTY_W-1:0] DUTY_MAX = 10'd1000;

   // Register indexes on the configuration port
   localparam logic [CSR_INDEX_W-1:0] CSR_DUTY_STEP     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DUTY_START    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SOC_FULL      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SOC_RESUME    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_POWER_MINIMUM = 3'd4;

   // Register reset values
   localparam logic [STEP_W-1:0]         RST_DUTY_STEP     = 7'd1;
   localparam logic [DUTY_W-1:0]         RST_DUTY_START    = 10'd500;
   localparam logic [SOC_W-1:0]          RST_SOC_FULL      = 10'd990;
   localparam logic [SOC_W-1:0]          RST_SOC_RESUME    = 10'd950;
   localparam logic signed [POWER_W-1:0] RST_POWER_MINIMUM = 24'sd0;

   typedef enum logic [1:0] {
      MODE_START    = 2'd0,
      MODE_CHARGING = 2'd1,
      MODE_OFF      = 2'd2,
      MODE_INVALID  = 2'd3
   } mode_type;

   typedef struct packed {
      logic [STEP_W-1:0]         duty_step;
      logic [DUTY_W-1:0]         duty_start;
      logic [SOC_W-1:0]          soc_full;
      logic [SOC_W-1:0]          soc_resume;
      logic signed [POWER_W-1:0] power_minimum;
   } cfg_type;

   typedef struct packed {
      logic signed [POWER_W-1:0] panel_power;
      logic [VOLT_W-1:0]         panel_voltage;
      logic [SOC_W-1:0]          charge_level;
   } item_type;

   typedef struct packed {
      mode_type                   mode;
      logic [DUTY_W-1:0]          duty;
      logic signed [NPOWER_W-1:0] prev_power;
      logic [VOLT_W-1:0]          prev_voltage;
   } state_type;

endpackage

### sv/scmppt_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scmppt_csr: configuration register file
// Holds the tracking step, start duty, charge thresholds and restart power,
// written one register at a time through the plain write port.
// ----------------------------------------------------------------------------
module scmppt_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [scmppt_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [scmppt_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output scmppt_pkg::cfg_type                  cfg
);

   scmppt_pkg::cfg_type cfg_ff;
   scmppt_pkg::cfg_type cfg_in;

   // Decode the write into the addressed field
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            scmppt_pkg::CSR_DUTY_STEP: begin
               cfg_in.duty_step = csr_wdata[scmppt_pkg::STEP_W-1:0];
            end
            scmppt_pkg::CSR_DUTY_START: begin
               cfg_in.duty_start = csr_wdata[scmppt_pkg::DUTY_W-1:0];
            end
            scmppt_pkg::CSR_SOC_FULL: begin
               cfg_in.soc_full = csr_wdata[scmppt_pkg::SOC_W-1:0];
            end
            scmppt_pkg::CSR_SOC_RESUME: begin
               cfg_in.soc_resume = csr_wdata[scmppt_pkg::SOC_W-1:0];
            end
            scmppt_pkg::CSR_POWER_MINIMUM: begin
               cfg_in.power_minimum = $signed(csr_wdata[scmppt_pkg::POWER_W-1:0]);
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.duty_step     <= scmppt_pkg::RST_DUTY_STEP;
         cfg_ff.duty_start    <= scmppt_pkg::RST_DUTY_START;
         cfg_ff.soc_full      <= scmppt_pkg::RST_SOC_FULL;
         cfg_ff.soc_resume    <= scmppt_pkg::RST_SOC_RESUME;
         cfg_ff.power_minimum <= scmppt_pkg::RST_POWER_MINIMUM;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### sv/scmppt_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scmppt_step: one controller step
// Computes the next mode, duty and stored power/voltage from the current
// state and one sample: start/charging/off sequencing plus perturb-and-
// observe tracking with the duty saturated to 0..1000.
// ----------------------------------------------------------------------------
module scmppt_step (
   input  scmppt_pkg::cfg_type    cfg,
   input  scmppt_pkg::state_type  state_cur,
   input  scmppt_pkg::item_type   item,
   output scmppt_pkg::state_type  state_nxt
);

   logic signed [scmppt_pkg::NPOWER_W-1:0] power;
   logic signed [scmppt_pkg::NPOWER_W-1:0] power_min_ext;
   logic                                   below_full;
   logic                                   below_resume;
   logic                                   power_ok;
   logic                                   p_up;
   logic                                   v_up;
   logic                                   power_moved;
   logic [scmppt_pkg::DUTY_W-1:0]          duty_step_ext;
   logic [scmppt_pkg::DUTY_W-1:0]          duty_dec;
   logic [scmppt_pkg::DUTY_W:0]            duty_sum;
   logic [scmppt_pkg::DUTY_W-1:0]          duty_inc;
   logic [scmppt_pkg::DUTY_W-1:0]          duty_track;
   logic [scmppt_pkg::DUTY_W-1:0]          duty_load;
   scmppt_pkg::mode_type                   mode_nxt;

   // Negate the measured power; the 25-bit result covers the full range
   assign power = '0 - {item.panel_power[scmppt_pkg::POWER_W-1], item.panel_power};
   assign power_min_ext = {cfg.power_minimum[scmppt_pkg::POWER_W-1], cfg.power_minimum};

   assign below_full   = item.charge_level < cfg.soc_full;
   assign below_resume = item.charge_level < cfg.soc_resume;
   assign power_ok     = power > power_min_ext;

   // Tracking direction
   assign power_moved = power != state_cur.prev_power;
   assign p_up        = power > state_cur.prev_power;
   assign v_up        = item.panel_voltage > state_cur.prev_voltage;

   // Saturating duty step down and up
   assign duty_step_ext = {{(scmppt_pkg::DUTY_W-scmppt_pkg::STEP_W){1'b0}}, cfg.duty_step};
   assign duty_dec = (state_cur.duty < duty_step_ext) ? '0 : state_cur.duty - duty_step_ext;
   assign duty_sum = {1'b0, state_cur.duty} + {1'b0, duty_step_ext};
   assign duty_inc = (duty_sum > {1'b0, scmppt_pkg::DUTY_MAX}) ? scmppt_pkg::DUTY_MAX
                                                              : duty_sum[scmppt_pkg::DUTY_W-1:0];
   assign duty_track = !power_moved ? state_cur.duty :
                       (p_up == v_up) ? duty_dec : duty_inc;

   assign duty_load = (cfg.duty_start > scmppt_pkg::DUTY_MAX) ? scmppt_pkg::DUTY_MAX
                                                             : cfg.duty_start;

   // Next mode
   always_comb begin
      mode_nxt = state_cur.mode;
      unique case (state_cur.mode)
         scmppt_pkg::MODE_START: begin
            mode_nxt = below_full ? scmppt_pkg::MODE_CHARGING : scmppt_pkg::MODE_OFF;
         end
         scmppt_pkg::MODE_CHARGING: begin
            if (!below_full) begin
               mode_nxt = scmppt_pkg::MODE_OFF;
            end
         end
         scmppt_pkg::MODE_OFF: begin
            if (power_ok && below_resume) begin
               mode_nxt = scmppt_pkg::MODE_START;
            end
         end
         scmppt_pkg::MODE_INVALID: begin
            mode_nxt = scmppt_pkg::MODE_INVALID;
         end
      endcase
   end

   // Duty and stored sample
   always_comb begin
      state_nxt      = state_cur;
      state_nxt.mode = mode_nxt;
      unique case (state_cur.mode)
         scmppt_pkg::MODE_START: begin
            if (below_full) begin
               state_nxt.duty = duty_load;
            end
         end
         scmppt_pkg::MODE_CHARGING: begin
            if (below_full) begin
               state_nxt.duty         = duty_track;
               state_nxt.prev_power   = power;
               state_nxt.prev_voltage = item.panel_voltage;
            end
         end
         scmppt_pkg::MODE_OFF: begin
            state_nxt.duty = '0;
         end
         scmppt_pkg::MODE_INVALID: begin
            state_nxt.duty = '0;
         end
      endcase
   end

endmodule

### sv/solar_charge_mppt_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// solar_charge_mppt_controller: battery charger with P&O power point tracking
// Pipeline: a sample word passes from the input register to the result
// register; a stalled result word holds both registers.
// Throughput: one sample word per cycle while the result port is not stalled.
// Reset: synchronous; mode start, duty 0, stored power/voltage 0, registers
// at their defaults, both pipeline registers empty.
// ----------------------------------------------------------------------------
module solar_charge_mppt_controller (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       req_valid,
   output logic                                       req_stall,
   input  logic signed [scmppt_pkg::POWER_W-1:0]      req_panel_power,
   input  logic [scmppt_pkg::VOLT_W-1:0]              req_panel_voltage,
   input  logic [scmppt_pkg::SOC_W-1:0]               req_charge_level,
   output logic                                       rsp_valid,
   input  logic                                       rsp_stall,
   output logic [scmppt_pkg::DUTY_W-1:0]              rsp_duty_level,
   output logic [1:0]                                 rsp_mode_now,
   input  logic                                       csr_wr_en,
   input  logic [scmppt_pkg::CSR_INDEX_W-1:0]         csr_index,
   input  logic [scmppt_pkg::CSR_DATA_W-1:0]          csr_wdata
);

   scmppt_pkg::cfg_type   cfg;
   scmppt_pkg::item_type  item_ff;
   scmppt_pkg::item_type  item_in;
   scmppt_pkg::state_type state_ff;
   scmppt_pkg::state_type state_nxt;
   scmppt_pkg::state_type state_in;
   logic                  item_vld_ff;
   logic                  item_vld_in;
   logic                  rsp_vld_ff;
   logic                  rsp_vld_in;
   logic [scmppt_pkg::DUTY_W-1:0] rsp_duty_ff;
   logic [scmppt_pkg::DUTY_W-1:0] rsp_duty_in;
   scmppt_pkg::mode_type  rsp_mode_ff;
   scmppt_pkg::mode_type  rsp_mode_in;
   logic                  step_adv;
   logic                  step_fire;
   logic                  req_fire;

   scmppt_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   scmppt_step u_step (
      .cfg       (cfg),
      .state_cur (state_ff),
      .item      (item_ff),
      .state_nxt (state_nxt)
   );

   // Handshake: the input register advances whenever the result slot frees up
   assign step_adv  = !rsp_vld_ff || !rsp_stall;
   assign step_fire = item_vld_ff && step_adv;
   assign req_stall = item_vld_ff && !step_adv;
   assign req_fire  = req_valid && !req_stall;

   // Input register
   always_comb begin
      item_vld_in = item_vld_ff;
      item_in     = item_ff;
      if (step_fire) begin
         item_vld_in = 1'b0;
      end
      if (req_fire) begin
         item_vld_in           = 1'b1;
         item_in.panel_power   = req_panel_power;
         item_in.panel_voltage = req_panel_voltage;
         item_in.charge_level  = req_charge_level;
      end
   end

   // Controller state and result register
   always_comb begin
      state_in    = state_ff;
      rsp_vld_in  = rsp_vld_ff && rsp_stall;
      rsp_duty_in = rsp_duty_ff;
      rsp_mode_in = rsp_mode_ff;
      if (step_fire) begin
         state_in    = state_nxt;
         rsp_vld_in  = 1'b1;
         rsp_duty_in = state_nxt.duty;
         rsp_mode_in = state_nxt.mode;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_vld_ff           <= 1'b0;
         rsp_vld_ff            <= 1'b0;
         state_ff.mode         <= scmppt_pkg::MODE_START;
         state_ff.duty         <= '0;
         state_ff.prev_power   <= '0;
         state_ff.prev_voltage <= '0;
      end else begin
         item_vld_ff <= item_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
         state_ff    <= state_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      rsp_duty_ff <= rsp_duty_in;
      rsp_mode_ff <= rsp_mode_in;
   end

   assign rsp_valid      = rsp_vld_ff;
   assign rsp_duty_level = rsp_duty_ff;
   assign rsp_mode_now   = rsp_mode_ff;

   // Duty never leaves the 0..1000 window
   a_duty_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.duty <= scmppt_pkg::DUTY_MAX)
      else $error("duty register above maximum");

   // The unused mode is never entered from a legal one
   a_no_invalid: assert property (@(posedge clock) disable iff (reset)
      state_ff.mode != scmppt_pkg::MODE_INVALID |=> state_ff.mode != scmppt_pkg::MODE_INVALID)
      else $error("controller entered the invalid mode");

   // State moves only when a sample word is processed
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !step_fire |=> state_ff == $past(state_ff))
      else $error("controller state changed without a sample");

   // Every processed sample leaves a result word
   a_step_result: assert property (@(posedge clock) disable iff (reset)
      step_fire |=> rsp_valid && rsp_duty_level == state_ff.duty)
      else $error("processed sample produced no result");

endmodule
